@@ hdl/ffsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared transaction types and status codes for the first-fit allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned ADDR_BITS = 20;
  localparam int unsigned OFF_W  = ADDR_BITS;
  localparam int unsigned REQ_W  = 20;
  localparam int unsigned CFG_W  = 21;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef struct packed {
    op_t              opcode;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] payload_offset;
    status_t          status;
  } out_item_t;

endpackage

@@ hdl/first_fit_segment_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit arena allocator keeping an address-ordered segment table in RAM.
// ----------------------------------------------------------------------------
// Usage: pulse start with an allocate or free transaction while busy is low.
// Exactly one result follows, shown for one cycle with out_valid; it cannot
// be stalled. The segment table lives in one synchronous RAM with registered
// read data; a search walks it from entry 0, one entry at a time (read, then
// check). A null free goes straight to the result. An allocate that fits
// shifts the later entries up one by one, writes the remainder after the
// found entry and then the used entry; a free that matches marks the entry
// free, then runs a compacting merge pass over the whole table. busy drops
// in the cycle the result is shown, so the next transaction can be accepted
// there. After reset busy stays high while entry 0 is initialised. A write
// of cfg_arena_bytes (only while idle) reinitialises the table with a single
// write, since only the entry count and entry 0 matter.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ffsa_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output ffsa_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [ffsa_pkg::CFG_W-1:0]  cfg_arena_bytes
);
  import ffsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned VAL_W = ADDR_BITS + 1;
  localparam logic [VAL_W-1:0] HDR = VAL_W'(HEADER_BYTES);
  localparam logic [VAL_W-1:0] LIMIT = VAL_W'(1) << ADDR_BITS;
  localparam logic [VAL_W-1:0] RST_ARENA = VAL_W'(65536);

  typedef struct packed {
    logic [VAL_W-1:0] start;
    logic [VAL_W-1:0] size;
    logic             free;
  } seg_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRD   = 10'b0000000010,  // search: read issued
    S_SCHK  = 10'b0000000100,  // search: data back
    S_SHRD  = 10'b0000001000,  // shift up: read k-1
    S_SHWR  = 10'b0000010000,  // shift up: write k
    S_SPLIT = 10'b0000100000,  // write remainder at i+1
    S_MRD   = 10'b0001000000,  // merge: read k
    S_MCHK  = 10'b0010000000,  // merge: data back
    S_MFIN  = 10'b0100000000,  // write held entry at i (merge end, or used entry on alloc)
    S_DONE  = 10'b1000000000
  } state_t;

  // Segment table RAM
  seg_t             mem [MAX_SEGMENTS];
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  seg_t             wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;        // search index / merge write index
  logic [CNT_W-1:0] k_r, k_nxt;        // shift / merge read index
  seg_t             hold_r, hold_nxt;  // found segment or merge accumulator
  in_item_t         op_r, op_nxt;
  out_item_t        res_r, res_nxt;
  logic             ov_r, ov_nxt;
  logic             init_r;
  logic [VAL_W-1:0] arena_c;
  logic [VAL_W-1:0] need;
  logic [VAL_W-1:0] tgt;

  assign need = VAL_W'(op_r.request_bytes) + HDR;
  assign tgt  = VAL_W'(op_r.free_offset);
  assign arena_c = (cfg_arena_bytes > CFG_W'(LIMIT)) ? LIMIT
                                                     : VAL_W'(cfg_arena_bytes);

  // Control and read-modify-write sequencing
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    hold_nxt  = hold_r;
    op_nxt    = op_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          we    = 1'b1;
          wdata = '{start: '0, size: arena_c - HDR, free: 1'b1};
          cnt_nxt = (arena_c < HDR) ? '0 : CNT_W'(1);
        end else if (init_r) begin
          // reset arena: entry 0 covers it, count already one
          we    = 1'b1;
          wdata = '{start: '0, size: RST_ARENA - HDR, free: 1'b1};
        end else if (start) begin
          op_nxt  = in_item;
          i_nxt   = '0;
          res_nxt = '{payload_offset: '0, status: ST_OK};
          if (in_item.opcode == OP_FREE && in_item.free_offset == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (i_r >= cnt_r) begin
          res_nxt.status = (op_r.opcode == OP_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
          state_nxt = S_DONE;
        end else begin
          raddr = i_r[IDX_W-1:0];
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        hold_nxt = rdata_r;
        if (op_r.opcode == OP_ALLOC) begin
          if (rdata_r.free && rdata_r.size >= need) begin
            if (cnt_r >= CNT_W'(MAX_SEGMENTS)) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              k_nxt = cnt_r;
              state_nxt = S_SHRD;
            end
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_SRD;
          end
        end else begin
          if (rdata_r.start + HDR == tgt) begin
            // mark free, then run a compacting merge from entry 0
            we    = 1'b1;
            waddr = i_r[IDX_W-1:0];
            wdata = rdata_r;
            wdata.free = 1'b1;
            i_nxt = '0;
            k_nxt = '0;
            state_nxt = S_MRD;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_SHRD: begin
        if (k_r > i_r + 1'b1) begin
          raddr = IDX_W'(k_r - 1'b1);
          state_nxt = S_SHWR;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SHWR: begin
        we    = 1'b1;
        waddr = k_r[IDX_W-1:0];
        wdata = rdata_r;
        k_nxt = k_r - 1'b1;
        state_nxt = S_SHRD;
      end
      S_SPLIT: begin
        // i+1 gets the remainder; i becomes used (written via hold next cycle)
        we    = 1'b1;
        waddr = IDX_W'(i_r + 1'b1);
        wdata = '{start: hold_r.start + need, size: hold_r.size - need, free: 1'b1};
        hold_nxt = '{start: hold_r.start, size: VAL_W'(op_r.request_bytes),
                     free: 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        res_nxt.payload_offset = OFF_W'(hold_r.start + HDR);
        state_nxt = S_MFIN;
      end
      S_MRD: begin
        if (k_r >= cnt_r) begin
          state_nxt = S_MFIN;
        end else begin
          raddr = k_r[IDX_W-1:0];
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        k_nxt = k_r + 1'b1;
        state_nxt = S_MRD;
        if (k_r == '0) begin
          hold_nxt = rdata_r;
        end else if (hold_r.free && rdata_r.free) begin
          hold_nxt.size = hold_r.size + HDR + rdata_r.size;
        end else begin
          we    = 1'b1;
          waddr = i_r[IDX_W-1:0];
          wdata = hold_r;
          hold_nxt = rdata_r;
          i_nxt = i_r + 1'b1;
        end
      end
      S_MFIN: begin
        we    = 1'b1;
        waddr = i_r[IDX_W-1:0];
        wdata = hold_r;
        if (op_r.opcode == OP_FREE) begin
          cnt_nxt = i_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= CNT_W'(1);
      ov_r    <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
    end
    hold_r <= hold_nxt;
    op_r   <= op_nxt;
    res_r  <= res_nxt;
  end

  // The RAM has no reset: entry 0 is written through the port while init_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b1;
    end else begin
      init_r <= 1'b0;
    end
  end

  assign busy      = (state_r != S_IDLE) || init_r;
  assign out_valid = ov_r;
  assign out_item  = res_r;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SEGMENTS)) else $error("segment count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("back-to-back results");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> ov_r) else $error("result lost");
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && res_r.status != ST_OK) |-> res_r.payload_offset == '0)
    else $error("offset on failed transaction");

endmodule

@@ tb/first_fit_segment_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb
// Self-checking bench for the first-fit segment allocator. A directed table
// covers the corner cases after reset, then several arena sizes (extremes
// included) are run with random allocate/free traffic under varying sender
// idle rates. Results are checked against typed rows or a segment-table model.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_tb;
  import ffsa_pkg::*;

  localparam int unsigned HDR       = 16;
  localparam int unsigned SEGS      = 64;
  localparam int unsigned ARENA_MAX = 1 << 20;
  localparam int unsigned DRAIN_CYC = 4 * SEGS + 16;
  localparam int unsigned CYC_LIMIT = 1000000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_arena_bytes;

  first_fit_segment_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_arena_bytes (cfg_arena_bytes)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Segment table model
  // ---------------------------------------------------------------------------
  logic [21:0] seg_base [SEGS];
  logic [21:0] seg_len  [SEGS];
  bit          seg_idle [SEGS];
  int unsigned seg_n;

  function automatic void arena_init(logic [CFG_W-1:0] bytes);
    logic [21:0] a;
    a = (bytes > ARENA_MAX) ? 22'(ARENA_MAX) : 22'(bytes);
    for (int i = 0; i < SEGS; i++) begin
      seg_base[i] = '0;
      seg_len[i]  = '0;
      seg_idle[i] = 1'b0;
    end
    if (a < HDR) begin
      seg_n = 0;
    end else begin
      seg_len[0]  = a - HDR;
      seg_idle[0] = 1'b1;
      seg_n       = 1;
    end
  endfunction

  function automatic void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < seg_n) begin
      if (seg_idle[i] && seg_idle[i+1]) begin
        seg_len[i] = seg_len[i] + HDR + seg_len[i+1];
        for (int unsigned k = i + 1; k + 1 < seg_n; k++) begin
          seg_base[k] = seg_base[k+1];
          seg_len[k]  = seg_len[k+1];
          seg_idle[k] = seg_idle[k+1];
        end
        seg_n--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic out_item_t allocator_step(in_item_t it);
    out_item_t   r;
    logic [21:0] need;
    int unsigned i;
    r.payload_offset = '0;
    r.status         = ST_OK;
    if (it.opcode == OP_ALLOC) begin
      need = 22'(it.request_bytes) + HDR;
      for (i = 0; i < seg_n; i++)
        if (seg_idle[i] && seg_len[i] >= need) break;
      if (i >= seg_n) begin
        r.status = ST_NO_FIT;
      end else if (seg_n >= SEGS) begin
        r.status = ST_FULL;
      end else begin
        for (int unsigned k = seg_n; k > i + 1; k--) begin
          seg_base[k] = seg_base[k-1];
          seg_len[k]  = seg_len[k-1];
          seg_idle[k] = seg_idle[k-1];
        end
        seg_base[i+1]    = seg_base[i] + need;
        seg_len[i+1]     = seg_len[i] - need;
        seg_idle[i+1]    = 1'b1;
        seg_len[i]       = 22'(it.request_bytes);
        seg_idle[i]      = 1'b0;
        seg_n++;
        r.payload_offset = OFF_W'(seg_base[i] + HDR);
      end
    end else if (it.free_offset != '0) begin
      for (i = 0; i < seg_n; i++)
        if (seg_base[i] + HDR == 22'(it.free_offset)) break;
      if (i >= seg_n) begin
        r.status = ST_BAD_FREE;
      end else begin
        seg_idle[i] = 1'b1;
        coalesce();
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  out_item_t   pending_results[$];
  int unsigned err_count;
  int unsigned result_count;
  int unsigned status_seen[4];

  function automatic void report_error(string what);
    err_count++;
    if (err_count <= 10) $display("[%0t] MISMATCH: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_count++;
      status_seen[out_item.status]++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result off=%0d st=%0d",
                               out_item.payload_offset, out_item.status));
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item.payload_offset !== want.payload_offset)
          report_error($sformatf("payload_offset exp %0d got %0d",
                                 want.payload_offset, out_item.payload_offset));
        if (out_item.status !== want.status)
          report_error($sformatf("status exp %0d got %0d",
                                 want.status, out_item.status));
      end
    end
  end

  // Watchdog
  int unsigned cycle_count;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0] live_offsets[$];
  int unsigned      items_sent;

  task automatic issue(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t r;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    r = allocator_step(it);
    pending_results.push_back(typed ? typed_res : r);
    if (it.opcode == OP_ALLOC && r.status == ST_OK) live_offsets.push_back(r.payload_offset);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap(int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Arena writes only once the block has drained
  task automatic write_arena(logic [CFG_W-1:0] bytes);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_arena_bytes <= bytes;
    cfg_we          <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    arena_init(bytes);
    live_offsets.delete();
    @(negedge clk);
  endtask

  function automatic in_item_t random_transaction();
    in_item_t    it;
    int unsigned pick, idx;
    it.request_bytes = REQ_W'($urandom);
    it.free_offset   = OFF_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.opcode = OP_ALLOC;
      pick = $urandom_range(99);
      if (pick < 70)      it.request_bytes = REQ_W'($urandom_range(0, 600));
      else if (pick < 92) it.request_bytes = REQ_W'($urandom_range(0, 8192));
    end else begin
      it.opcode = OP_FREE;
      pick = $urandom_range(99);
      if (pick < 88 && live_offsets.size() != 0) begin
        idx = $urandom_range(live_offsets.size() - 1);
        it.free_offset = live_offsets[idx];
        // occasionally leave it listed so a double free follows later
        if ($urandom_range(9) != 0) live_offsets.delete(idx);
      end else if (pick < 94) begin
        it.free_offset = '0;
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table, written against the reset arena of 65536 bytes
  // ---------------------------------------------------------------------------
  typedef struct {
    op_t              op;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] off;
    bit               typed;
    logic [OFF_W-1:0] exp_off;
    status_t          exp_st;
  } dir_row_t;

  localparam int unsigned N_DIR = 16;
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_ALLOC, 20'd0,       20'd0,       1'b1, 20'd16, ST_OK},        // first alloc
    '{OP_ALLOC, 20'hFFFFF,   20'd0,       1'b1, 20'd0,  ST_NO_FIT},    // largest request
    '{OP_FREE,  20'd0,       20'd0,       1'b1, 20'd0,  ST_OK},        // null free
    '{OP_FREE,  20'd0,       20'd5,       1'b1, 20'd0,  ST_BAD_FREE},  // unknown offset
    '{OP_FREE,  20'd0,       20'd16,      1'b1, 20'd0,  ST_OK},
    '{OP_FREE,  20'd0,       20'd16,      1'b1, 20'd0,  ST_OK},        // double free
    '{OP_ALLOC, 20'd65504,   20'd0,       1'b1, 20'd16, ST_OK},        // exact fit
    '{OP_ALLOC, 20'd0,       20'd0,       1'b1, 20'd0,  ST_NO_FIT},    // zero-byte rest
    '{OP_FREE,  20'd0,       20'hFFFFF,   1'b1, 20'd0,  ST_BAD_FREE},
    '{OP_FREE,  20'd0,       20'd16,      1'b1, 20'd0,  ST_OK},
    '{OP_ALLOC, 20'hAAAAA,   20'h55555,   1'b1, 20'd0,  ST_NO_FIT},
    '{OP_FREE,  20'h55555,   20'hAAAAA,   1'b1, 20'd0,  ST_BAD_FREE},
    '{OP_ALLOC, 20'd100,     20'hFFFFF,   1'b0, 20'd0,  ST_OK},
    '{OP_ALLOC, 20'd200,     20'd0,       1'b0, 20'd0,  ST_OK},
    '{OP_FREE,  20'hFFFFF,   20'd16,      1'b0, 20'd0,  ST_OK},
    '{OP_ALLOC, 20'd50,      20'd0,       1'b0, 20'd0,  ST_OK}
  };

  // Arena settings per phase, extremes included
  localparam int unsigned N_PHASE = 9;
  logic [CFG_W-1:0] phase_arena [N_PHASE] = '{
    21'd65536, 21'd1048576, 21'd0, 21'd15, 21'd16,
    21'h1FFFFF, 21'd1024, 21'd4096, 21'd65536
  };
  int unsigned phase_items [N_PHASE] = '{120, 100, 15, 15, 20, 100, 80, 120, 130};
  int unsigned phase_idle  [3]       = '{0, 73, 14};

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t  it;
    out_item_t typed_res;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    cfg_we          = 1'b0;
    cfg_arena_bytes = '0;
    err_count       = 0;
    result_count    = 0;
    items_sent      = 0;
    cycle_count     = 0;
    status_seen     = '{0, 0, 0, 0};
    arena_init(21'd65536);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      it.opcode              = dir_rows[i].op;
      it.request_bytes       = dir_rows[i].req;
      it.free_offset         = dir_rows[i].off;
      typed_res.payload_offset = dir_rows[i].exp_off;
      typed_res.status         = dir_rows[i].exp_st;
      issue(it, dir_rows[i].typed, typed_res);
      sender_gap(30);
    end

    for (int p = 0; p < N_PHASE; p++) begin
      write_arena(phase_arena[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        issue(random_transaction(), 1'b0, '0);
        sender_gap(phase_idle[p % 3]);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    err_count += pending_results.size();

    $display("Ran %0d transactions over %0d arena settings; %0d results checked.",
             items_sent, N_PHASE + 1, result_count);
    $display("Status mix: ok %0d, no fit %0d, table full %0d, unknown free %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ffsa_pkg.sv
hdl/first_fit_segment_allocator.sv
tb/first_fit_segment_allocator_tb.sv
